/* hdl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check, ignored while reset is held
`define TRC_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("trc assertion failed");

// concurrent check that also holds across reset
`define TRC_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("trc assertion failed");

`endif

/* hdl/trc_pkg.sv */
`default_nettype none

package trc_pkg;

    localparam int CHANNELS  = 16;
    localparam int CHAN_W    = $clog2(CHANNELS);
    localparam int ACTION_W  = 3;
    localparam int ADC_W     = 10;
    localparam int CAL_W     = 8;
    localparam int VALUE_W   = 16;
    localparam int CFG_IDX_W = 1;

    localparam int SEGMENTS  = 15;
    localparam int SEG_IDX_W = 4;
    localparam int SEG_W     = 7;
    localparam int SUM_W     = 11;
    localparam int T_W       = 13;
    localparam int DIV_STEPS = 7;
    localparam int DIV_CNT_W = 3;

    localparam logic [SEG_W-1:0] SEG_TABLE [SEGMENTS] = '{
        7'd56, 7'd41, 7'd61, 7'd83, 7'd102, 7'd113, 7'd112, 7'd101,
        7'd85, 7'd67, 7'd51, 7'd38, 7'd28, 7'd21, 7'd65
    };

    localparam logic [ACTION_W-1:0] ACT_RAW       = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_THERM     = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_PERCENT   = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_ONOFF     = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_ONOFF_INV = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_FAHRENHEIT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_OFFSET = 1'd1;

    localparam logic [CAL_W-1:0] CAL_OFFSET_RESET = 8'd128;

    localparam logic signed [T_W-1:0] T_ABOVE_TABLE = 13'sd1400;
    localparam logic signed [T_W-1:0] T_BELOW_TABLE = -13'sd1000;
    localparam logic signed [T_W-1:0] T_SEG_BASE    = 13'sd400;
    localparam logic signed [T_W-1:0] T_F_OFFSET    = 13'sd320;

    // round(2^18 / 5), exact for the magnitudes seen here
    localparam logic [15:0] RECIP_5 = 16'd52429;

    typedef struct packed {
        logic load_item;
        logic walk_step;
        logic t_above;
        logic t_below;
        logic div_start;
        logic div_step;
        logic t_make;
        logic fahr_mul;
        logic fahr_scale;
        logic out_load;
    } trc_cmd_t;

    typedef struct packed {
        logic sum_gt;
        logic k_top;
        logic k_zero;
        logic div_last;
        logic fahr_en;
    } trc_stat_t;

endpackage

`default_nettype wire

/* hdl/trc_ctrl.sv */
`default_nettype none

module trc_ctrl (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [trc_pkg::ACTION_W-1:0] s_action,
    output logic                         m_valid,
    input  logic                         m_ready,
    input  trc_pkg::trc_stat_t           stat,
    output trc_pkg::trc_cmd_t            cmd
);
    import trc_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE       = 7'b0000001,
        S_WALK       = 7'b0000010,
        S_DIV        = 7'b0000100,
        S_TEMP       = 7'b0001000,
        S_FAHR_MUL   = 7'b0010000,
        S_FAHR_SCALE = 7'b0100000,
        S_DONE       = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    state_next    = (s_action == ACT_THERM) ? S_WALK : S_DONE;
                end
            end
            S_WALK: begin
                if (stat.sum_gt) begin
                    if (stat.k_top) begin
                        // count below the last segment
                        cmd.t_above = 1'b1;
                        state_next  = stat.fahr_en ? S_FAHR_MUL : S_DONE;
                    end else begin
                        cmd.div_start = 1'b1;
                        state_next    = S_DIV;
                    end
                end else if (stat.k_zero) begin
                    cmd.t_below = 1'b1;
                    state_next  = stat.fahr_en ? S_FAHR_MUL : S_DONE;
                end else begin
                    cmd.walk_step = 1'b1;
                end
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (stat.div_last) begin
                    state_next = S_TEMP;
                end
            end
            S_TEMP: begin
                cmd.t_make = 1'b1;
                state_next = stat.fahr_en ? S_FAHR_MUL : S_DONE;
            end
            S_FAHR_MUL: begin
                cmd.fahr_mul = 1'b1;
                state_next   = S_FAHR_SCALE;
            end
            S_FAHR_SCALE: begin
                cmd.fahr_scale = 1'b1;
                state_next     = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

`default_nettype wire

/* hdl/trc_datapath.sv */
`default_nettype none

module trc_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [trc_pkg::ACTION_W-1:0]        s_action,
    input  logic [trc_pkg::ADC_W-1:0]           s_adc_count,
    input  logic [trc_pkg::CHAN_W-1:0]          s_channel,
    input  logic [trc_pkg::CAL_W-1:0]           s_calibration,
    input  logic                                cfg_wr_en,
    input  logic [trc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [trc_pkg::CAL_W-1:0]           cfg_wr_data,
    input  trc_pkg::trc_cmd_t                   cmd,
    output trc_pkg::trc_stat_t                  stat,
    output logic signed [trc_pkg::VALUE_W-1:0]  m_value
);
    import trc_pkg::*;

    // x / 1023 for x < 2^17: x/1024 estimate, remainder stays below 2*1023
    function automatic logic [6:0] div1023(input logic [16:0] x);
        logic [6:0]  q0;
        logic [10:0] r;
        q0 = x[16:10];
        r  = {1'b0, x[9:0]} + {4'b0, q0};
        return (r >= 11'd1023) ? (q0 + 7'd1) : q0;
    endfunction

    // item registers
    logic [ACTION_W-1:0]  action_reg;
    logic [ADC_W-1:0]     count_reg;
    logic [CHAN_W-1:0]    chan_reg;
    logic [CAL_W-1:0]     cal_reg;

    // configuration and held status
    logic                 fahr_reg;
    logic [CAL_W-1:0]     cal_off_reg;
    logic [CHANNELS-1:0]  status_reg, status_next;

    // table walk and divider
    logic [SUM_W-1:0]     sum_reg;
    logic [SEG_IDX_W-1:0] k_reg;
    logic [13:0]          rem_reg;
    logic [SEG_W-1:0]     dvs_reg;
    logic [6:0]           q_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;

    // temperature path
    logic signed [T_W-1:0] t_reg;
    logic [13:0]           fx_reg;
    logic                  fneg_reg;
    logic signed [VALUE_W-1:0] m_value_reg;

    logic [SEG_IDX_W-1:0]  k_dec;
    logic [SUM_W-1:0]      diff;
    logic [13:0]           dividend;
    logic [13:0]           trial;
    logic                  trial_ok;
    logic [12:0]           k100;
    logic signed [T_W-1:0] t_seg;
    logic [T_W-2:0]        t_mag;
    logic [29:0]           fprod;
    logic [11:0]           fdeg;
    logic signed [T_W-1:0] t_fahr;
    logic [VALUE_W-1:0]    bias16;
    logic [16:0]           pct_prod;
    logic [16:0]           sw_prod;
    logic [6:0]            pct;
    logic [6:0]            sw;
    logic                  inv;
    logic                  st_new;
    logic                  is_onoff;
    logic [VALUE_W-1:0]    out_val;

    assign k_dec    = k_reg - 1'b1;
    assign diff     = sum_reg - {1'b0, count_reg};
    assign dividend = {7'b0, diff[SEG_W-1:0]} * 14'd100;
    assign trial    = {7'b0, dvs_reg} << cnt_reg;
    assign trial_ok = (rem_reg >= trial);

    // q + k*100 - 400 covers segments on both sides of zero
    assign k100  = {9'b0, k_reg} * 13'd100;
    assign t_seg = $signed({6'b0, q_reg}) + $signed(k100) - T_SEG_BASE;

    assign t_mag  = t_reg[T_W-1] ? 12'(-t_reg) : t_reg[T_W-2:0];
    assign fprod  = {16'b0, fx_reg} * {14'b0, RECIP_5};
    assign fdeg   = fprod[29:18];
    assign t_fahr = (fneg_reg ? -$signed({1'b0, fdeg}) : $signed({1'b0, fdeg})) + T_F_OFFSET;

    assign bias16   = {8'b0, cal_reg} - {8'b0, cal_off_reg};
    assign pct_prod = {7'b0, count_reg} * 17'd100;
    assign sw_prod  = {7'b0, count_reg} * 17'd50;
    assign pct      = div1023(pct_prod);
    assign sw       = div1023(sw_prod);

    assign inv      = (action_reg == ACT_ONOFF_INV);
    assign is_onoff = (action_reg == ACT_ONOFF) || (action_reg == ACT_ONOFF_INV);

    always_comb begin
        if (sw <= 7'd24) begin
            st_new = inv;
        end else if (sw >= 7'd26) begin
            st_new = !inv;
        end else begin
            // deadband keeps the held status
            st_new = status_reg[chan_reg];
        end
    end

    always_comb begin
        case (action_reg)
            ACT_RAW:       out_val = {6'b0, count_reg} + bias16;
            ACT_THERM:     out_val = {{(VALUE_W-T_W){t_reg[T_W-1]}}, t_reg} + bias16;
            ACT_PERCENT:   out_val = {9'b0, pct};
            ACT_ONOFF:     out_val = {15'b0, st_new};
            ACT_ONOFF_INV: out_val = {15'b0, st_new};
            default:       out_val = '0;
        endcase
    end

    always_comb begin
        status_next = status_reg;
        if (cmd.out_load && is_onoff) begin
            status_next[chan_reg] = st_new;
        end
    end

    assign stat.sum_gt   = (sum_reg > {1'b0, count_reg});
    assign stat.k_top    = (k_reg == SEG_IDX_W'(SEGMENTS - 1));
    assign stat.k_zero   = (k_reg == '0);
    assign stat.div_last = (cnt_reg == '0);
    assign stat.fahr_en  = fahr_reg;

    assign m_value = m_value_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fahr_reg    <= 1'b0;
            cal_off_reg <= CAL_OFFSET_RESET;
            status_reg  <= '0;
        end else begin
            status_reg <= status_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_FAHRENHEIT: fahr_reg    <= cfg_wr_data[0];
                    CFG_CAL_OFFSET: cal_off_reg <= cfg_wr_data;
                    default:        fahr_reg    <= fahr_reg;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            action_reg <= s_action;
            count_reg  <= s_adc_count;
            chan_reg   <= s_channel;
            cal_reg    <= s_calibration;
            sum_reg    <= SUM_W'(SEG_TABLE[SEGMENTS-1]);
            k_reg      <= SEG_IDX_W'(SEGMENTS - 1);
        end
        if (cmd.walk_step) begin
            k_reg   <= k_dec;
            sum_reg <= sum_reg + SUM_W'(SEG_TABLE[k_dec]);
        end
        if (cmd.div_start) begin
            rem_reg <= dividend;
            dvs_reg <= SEG_TABLE[k_reg];
            q_reg   <= '0;
            cnt_reg <= DIV_CNT_W'(DIV_STEPS - 1);
        end
        if (cmd.div_step) begin
            q_reg   <= {q_reg[5:0], trial_ok};
            cnt_reg <= cnt_reg - 1'b1;
            if (trial_ok) begin
                rem_reg <= rem_reg - trial;
            end
        end
        if (cmd.t_above) begin
            t_reg <= T_ABOVE_TABLE;
        end
        if (cmd.t_below) begin
            t_reg <= T_BELOW_TABLE;
        end
        if (cmd.t_make) begin
            t_reg <= t_seg;
        end
        if (cmd.fahr_mul) begin
            fx_reg   <= {2'b0, t_mag} * 14'd9;
            fneg_reg <= t_reg[T_W-1];
        end
        if (cmd.fahr_scale) begin
            t_reg <= t_fahr;
        end
        if (cmd.out_load) begin
            m_value_reg <= $signed(out_val);
        end
    end

endmodule

`default_nettype wire

/* hdl/thermistor_range_converter_core.sv */
`default_nettype none

// channel   | handshake             | payload
// ----------+-----------------------+---------------------------------------------
// input     | s_valid / s_ready     | s_action, s_adc_count, s_channel, s_calibration
// result    | m_valid / m_ready     | m_value
// config    | cfg_wr_en (no wait)   | cfg_index, cfg_wr_data
//
// raw, percent, on/off and unused codes go straight from the load to the result.
// thermistor: a table walk over up to 15 segments (one segment a cycle through
// the running-sum adder), 7 divider steps plus one to form the result when the walk
// ends inside the table, and a multiply and a scale step with fahrenheit set.
// the result register lets the next transaction in while m_value waits on m_ready.
// synchronous reset clears held on/off status, m_valid and fahrenheit; offset to 128.
module thermistor_range_converter_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [trc_pkg::ACTION_W-1:0]        s_action,
    input  logic [trc_pkg::ADC_W-1:0]           s_adc_count,
    input  logic [trc_pkg::CHAN_W-1:0]          s_channel,
    input  logic [trc_pkg::CAL_W-1:0]           s_calibration,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [trc_pkg::VALUE_W-1:0]  m_value,
    input  logic                                cfg_wr_en,
    input  logic [trc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [trc_pkg::CAL_W-1:0]           cfg_wr_data
);
    import trc_pkg::*;

    trc_cmd_t  cmd;
    trc_stat_t stat;

    trc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_action (s_action),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    trc_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_action      (s_action),
        .s_adc_count   (s_adc_count),
        .s_channel     (s_channel),
        .s_calibration (s_calibration),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data),
        .cmd           (cmd),
        .stat          (stat),
        .m_value       (m_value)
    );

endmodule

`default_nettype wire

/* hdl/trc_checker.sv */
`default_nettype none

`include "assert_macros.svh"

module trc_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_valid,
    input logic                                s_ready,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic signed [trc_pkg::VALUE_W-1:0]  m_value
);

    // transactions taken in but not yet handed out
    logic [1:0] pending_reg, pending_next;
    logic       s_fire, m_fire;

    assign s_fire = s_valid && s_ready;
    assign m_fire = m_valid && m_ready;

    always_comb begin
        pending_next = pending_reg;
        if (s_fire && !m_fire) begin
            pending_next = pending_reg + 2'd1;
        end else if (m_fire && !s_fire) begin
            pending_next = pending_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
        end else begin
            pending_reg <= pending_next;
        end
    end

    `TRC_ASSERT(a_result_held, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_value))
    `TRC_ASSERT(a_no_spurious_result, aclk, aresetn, m_valid |-> pending_reg != 2'd0)
    `TRC_ASSERT(a_one_in_core, aclk, aresetn, s_ready |-> pending_reg <= 2'd1)
    `TRC_ASSERT_ALWAYS(a_reset_clears_valid, aclk, !aresetn |=> !m_valid)

endmodule

bind thermistor_range_converter_core trc_checker u_trc_checker (.*);

`default_nettype wire
